[rtl/bqn_pkg.sv]
// Package for the biquad notch filter: widths, payload structs, register
// indexes and the controller-to-datapath command struct.
// No dependencies.
package bqn_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 32;
    localparam int COEF_FRAC    = COEF_WIDTH - 2;
    localparam int DELAY_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int NUM_COEFS    = 5;
    localparam int CFG_IDX_W    = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // operation codes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                            operation;
        logic signed [SAMPLE_WIDTH-1:0]  sample_in;
        logic                            last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  sample_out;
        logic                            last_out;
        logic                            clipped;
    } t_out_item;

    // operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_X_B0,
        MUL_X_B1,
        MUL_Y_A1,
        MUL_X_B2,
        MUL_Y_A2
    } t_mul_sel;

    typedef struct packed {
        logic     latch_in;   // capture sample and last flag
        logic     clear;      // zero both delays
        t_mul_sel mul_sel;
        logic     calc_y;     // y = b0*x + d1, rounded and saturated
        logic     acc_load;   // acc = product (+ d2)
        logic     acc_add_d2;
        logic     upd_d1;     // d1 = sat(acc - product)
        logic     upd_d2;     // d2 = sat(acc - product)
        logic     load_out;   // move result into output register
    } t_dp_cmd;

endpackage

[rtl/bqn_datapath.sv]
// Datapath of the biquad notch filter: coefficient registers, shared
// 16x32 multiplier with product register, accumulator and delay registers.
// Depends on bqn_pkg.
module bqn_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bqn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bqn_pkg::COEF_WIDTH-1:0]  i_cfg_data,
    input  bqn_pkg::t_in_item               i_in_data,
    input  bqn_pkg::t_dp_cmd                i_cmd,
    output bqn_pkg::t_out_item              o_out_data
);
    import bqn_pkg::*;

    localparam int PW = DELAY_WIDTH;
    localparam int AW = PW + 2;
    localparam int YW = AW - COEF_FRAC;
    localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);
    localparam logic signed [PW-1:0] DMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] DMIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y;
    logic                           r_last, r_clip;
    logic signed [PW-1:0]           r_prod, r_d1, r_d2;
    logic signed [AW-1:0]           r_acc;
    t_out_item                      r_out;

    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [COEF_WIDTH-1:0]   mul_b;
    logic signed [PW-1:0]           n_prod;
    logic signed [AW-1:0]           prod_ext, d1_ext, d2_ext, y_sum, d_diff;
    logic signed [YW-1:0]           y_shift;
    logic signed [SAMPLE_WIDTH-1:0] n_y;
    logic                           n_clip, d_ovf;
    logic signed [PW-1:0]           n_dsat;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_X_B0: begin mul_a = r_x; mul_b = r_b0; end
            MUL_X_B1: begin mul_a = r_x; mul_b = r_b1; end
            MUL_Y_A1: begin mul_a = r_y; mul_b = r_a1; end
            MUL_X_B2: begin mul_a = r_x; mul_b = r_b2; end
            MUL_Y_A2: begin mul_a = r_y; mul_b = r_a2; end
            default:  begin mul_a = r_x; mul_b = r_b0; end
        endcase
    end

    assign n_prod   = mul_a * mul_b;
    assign prod_ext = {{2{r_prod[PW-1]}}, r_prod};
    assign d1_ext   = {{2{r_d1[PW-1]}}, r_d1};
    assign d2_ext   = {{2{r_d2[PW-1]}}, r_d2};

    // output sample: round half up, drop fraction, saturate
    assign y_sum   = prod_ext + d1_ext + HALF;
    assign y_shift = YW'(y_sum >>> COEF_FRAC);

    always_comb begin
        n_clip = (y_shift[YW-1:SAMPLE_WIDTH-1] != {(YW-SAMPLE_WIDTH+1){1'b0}}) &&
                 (y_shift[YW-1:SAMPLE_WIDTH-1] != {(YW-SAMPLE_WIDTH+1){1'b1}});
        if (!n_clip) begin
            n_y = y_shift[SAMPLE_WIDTH-1:0];
        end else if (y_shift[YW-1]) begin
            n_y = SMIN;
        end else begin
            n_y = SMAX;
        end
    end

    // delay update: acc minus feedback product, saturated to delay width
    assign d_diff = r_acc - prod_ext;
    assign d_ovf  = (d_diff[AW-1:PW-1] != 3'b000) && (d_diff[AW-1:PW-1] != 3'b111);
    always_comb begin
        if (!d_ovf) begin
            n_dsat = d_diff[PW-1:0];
        end else if (d_diff[AW-1]) begin
            n_dsat = DMIN;
        end else begin
            n_dsat = DMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_WIDTH'(1) << COEF_FRAC;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_B0:  r_b0 <= i_cfg_data;
                    REG_B1:  r_b1 <= i_cfg_data;
                    REG_B2:  r_b2 <= i_cfg_data;
                    REG_A1:  r_a1 <= i_cfg_data;
                    REG_A2:  r_a2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end else begin
                if (i_cmd.upd_d1) r_d1 <= n_dsat;
                if (i_cmd.upd_d2) r_d2 <= n_dsat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_cmd.latch_in) begin
            r_x    <= i_in_data.sample_in;
            r_last <= i_in_data.last_in;
        end
        if (i_cmd.calc_y) begin
            r_y    <= n_y;
            r_clip <= n_clip;
        end
        if (i_cmd.acc_load) begin
            r_acc <= prod_ext + (i_cmd.acc_add_d2 ? d2_ext : {AW{1'b0}});
        end
        if (i_cmd.load_out) begin
            r_out.sample_out <= r_y;
            r_out.last_out   <= r_last;
            r_out.clipped    <= r_clip;
        end
    end

    assign o_out_data = r_out;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_d1 == '0) && (r_d2 == '0))
        else $error("delays not zero after clear");

endmodule

[rtl/bqn_ctrl.sv]
// Sequencer of the biquad notch filter: accepts items, steps the shared
// multiplier through the five products and owns the output valid flag.
// Depends on bqn_pkg.
module bqn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bqn_pkg::t_dp_cmd  o_cmd
);
    import bqn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MB0,
        S_Y,
        S_MA1,
        S_D1,
        S_MA2,
        S_D2,
        S_OUT
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    in_fire, out_free;
    t_dp_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_X_B0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_op == OP_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.latch_in = 1'b1;
                        n_state      = S_MB0;
                    end
                end
            end
            S_MB0: begin
                cmd.mul_sel = MUL_X_B0;
                n_state     = S_Y;
            end
            S_Y: begin
                cmd.calc_y  = 1'b1;
                cmd.mul_sel = MUL_X_B1;
                n_state     = S_MA1;
            end
            S_MA1: begin
                cmd.acc_load   = 1'b1;
                cmd.acc_add_d2 = 1'b1;
                cmd.mul_sel    = MUL_Y_A1;
                n_state        = S_D1;
            end
            S_D1: begin
                cmd.upd_d1  = 1'b1;
                cmd.mul_sel = MUL_X_B2;
                n_state     = S_MA2;
            end
            S_MA2: begin
                cmd.acc_load = 1'b1;
                cmd.mul_sel  = MUL_Y_A2;
                n_state      = S_D2;
            end
            S_D2: begin
                cmd.upd_d2 = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // wait here while the previous result is still unclaimed
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> out_free)
        else $error("output register overwritten before transfer");

    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_op == OP_FILTER) |=> (r_state == S_MB0))
        else $error("filter item did not start sequence");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_op == OP_CLEAR && !r_out_valid) |=> !r_out_valid)
        else $error("clear produced a result");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.calc_y, cmd.upd_d1, cmd.upd_d2, cmd.load_out, cmd.latch_in}))
        else $error("overlapping datapath steps");

endmodule

[rtl/biquad_notch_filter_tdf2.sv]
// Top level of the biquad notch filter (transposed direct form II).
// Instantiates bqn_ctrl and bqn_datapath; depends on bqn_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): operation 0 filters
//   one Q1.15 sample, operation 1 zeroes both 48-bit delays and gives no
//   result. Output channel (o_out_valid / i_out_ready / o_out_data) carries
//   the saturated Q1.15 sample, the last-of-block copy and a clip flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes Q2.30 coefficients b0, b1, b2, a1, a2 at indexes 0..4;
//   other indexes are dropped. Write only while the filter is idle.
//   Sequence: a filter item steps through S_MB0, S_Y, S_MA1, S_D1, S_MA2,
//   S_D2 and S_OUT before output valid; the next item can be taken in the
//   cycle after its result is loaded, so no new sample is accepted while
//   one is in work. The single 16x32 multiplier is used once per cycle for
//   the five products. A clear zeroes the delays. The output register holds
//   a finished result while the next item is taken; if the receiver stalls,
//   the following result waits in the sequencer and input ready stays low.
//   Reset: synchronous, active low; delays zero, b0 = 1.0, others 0.
module biquad_notch_filter_tdf2 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bqn_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bqn_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bqn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bqn_pkg::COEF_WIDTH-1:0]  i_cfg_data
);
    import bqn_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bqn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.operation),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bqn_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule
